// ----- src/link_connect_retry_supervisor_core_defines.svh -----
// Assertion macros used by the supervisor checker.
`ifndef LINK_CONNECT_RETRY_SUPERVISOR_CORE_DEFINES_SVH
`define LINK_CONNECT_RETRY_SUPERVISOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define LCRS_CHECK(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcrs check failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define LCRS_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcrs check failed");

`endif

// ----- src/lcrs_pkg.sv -----
// Types, constants and helpers of the link connect/retry supervisor.
package lcrs_pkg;

   // Width of the wait down-timer.
   localparam int TIMER_BITS = 16;

   localparam int WAIT_BITS  = 16;
   localparam int COUNT_BITS = 4;
   localparam int INDEX_BITS = 3;
   localparam int DATA_BITS  = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 4'd15;

   // Configuration register indexes.
   localparam logic [INDEX_BITS-1:0] CSR_ENABLE       = 3'd0;
   localparam logic [INDEX_BITS-1:0] CSR_INVALID_WAIT = 3'd1;
   localparam logic [INDEX_BITS-1:0] CSR_CREATE_WAIT  = 3'd2;
   localparam logic [INDEX_BITS-1:0] CSR_CONNECT_WAIT = 3'd3;
   localparam logic [INDEX_BITS-1:0] CSR_CLOSE_WAIT   = 3'd4;
   localparam logic [INDEX_BITS-1:0] CSR_SILENCE_WAIT = 3'd5;
   localparam logic [INDEX_BITS-1:0] CSR_ERROR_LIMIT  = 3'd6;

   // Link status codes.
   localparam logic [1:0] LINK_CLOSED     = 2'd0;
   localparam logic [1:0] LINK_CONNECTING = 2'd1;
   localparam logic [1:0] LINK_READY      = 2'd2;

   // State codes as they appear on the result channel.
   localparam logic [2:0] CODE_INVALID = 3'd0;
   localparam logic [2:0] CODE_CREATE  = 3'd1;
   localparam logic [2:0] CODE_CONNECT = 3'd2;
   localparam logic [2:0] CODE_READY   = 3'd3;
   localparam logic [2:0] CODE_CLOSE   = 3'd4;
   localparam logic [2:0] CODE_SILENCE = 3'd5;

   // Supervisor states, one-hot.
   typedef enum logic [5:0] {
      ST_INVALID = 6'b000001,
      ST_CREATE  = 6'b000010,
      ST_CONNECT = 6'b000100,
      ST_READY   = 6'b001000,
      ST_CLOSE   = 6'b010000,
      ST_SILENCE = 6'b100000
   } state_type;

   typedef struct packed {
      logic                  enable;
      logic [WAIT_BITS-1:0]  invalid_wait;
      logic [WAIT_BITS-1:0]  create_wait;
      logic [WAIT_BITS-1:0]  connect_wait;
      logic [WAIT_BITS-1:0]  close_wait;
      logic [WAIT_BITS-1:0]  silence_wait;
      logic [COUNT_BITS-1:0] error_limit;
   } cfg_type;

   typedef struct packed {
      state_type             state;
      logic                  entry_pending;
      logic [TIMER_BITS-1:0] timer;
      logic [COUNT_BITS-1:0] tally;
      logic [1:0]            link;
      logic                  silence;
   } sup_type;

   typedef struct packed {
      logic modem_ready;
      logic connect_failed;
      logic link_dropped;
      logic send_failed;
   } tick_type;

   typedef struct packed {
      logic [2:0]            state_code;
      logic [1:0]            link_status;
      logic                  reload_address;
      logic                  connect_attempt;
      logic                  close_request;
      logic                  send_slot;
      logic                  backoff_flag;
      logic [COUNT_BITS-1:0] error_count;
   } rsp_type;

   localparam cfg_type CFG_RESET = '{
      enable:       1'b0,
      invalid_wait: 16'd100,
      create_wait:  16'd100,
      connect_wait: 16'd50,
      close_wait:   16'd500,
      silence_wait: 16'd12000,
      error_limit:  4'd3
   };

   localparam sup_type SUP_RESET = '{
      state:         ST_INVALID,
      entry_pending: 1'b1,
      timer:         '0,
      tally:         '0,
      link:          LINK_CLOSED,
      silence:       1'b0
   };

   // Saturating error count increment.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] value);
      return (value == COUNT_MAX) ? COUNT_MAX : value + 1'b1;
   endfunction

   // External state code of a one-hot state.
   function automatic logic [2:0] code_of(input state_type state);
      logic [2:0] code;
      unique case (state)
         ST_INVALID: code = CODE_INVALID;
         ST_CREATE:  code = CODE_CREATE;
         ST_CONNECT: code = CODE_CONNECT;
         ST_READY:   code = CODE_READY;
         ST_CLOSE:   code = CODE_CLOSE;
         ST_SILENCE: code = CODE_SILENCE;
         default:    code = CODE_CLOSE;
      endcase
      return code;
   endfunction

endpackage

// ----- src/lcrs_if.sv -----
// Channel interfaces of the supervisor: tick requests, results and configuration writes.
interface lcrs_req_if;
   logic valid;
   logic ready;
   logic modem_ready;
   logic connect_failed;
   logic link_dropped;
   logic send_failed;

   modport source (output valid, modem_ready, connect_failed, link_dropped, send_failed,
                   input ready);
   modport sink   (input valid, modem_ready, connect_failed, link_dropped, send_failed,
                   output ready);
endinterface

interface lcrs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     state_code;
   logic [1:0]                     link_status;
   logic                           reload_address;
   logic                           connect_attempt;
   logic                           close_request;
   logic                           send_slot;
   logic                           backoff_flag;
   logic [lcrs_pkg::COUNT_BITS-1:0] error_count;

   modport source (output valid, state_code, link_status, reload_address, connect_attempt,
                          close_request, send_slot, backoff_flag, error_count,
                   input ready);
   modport sink   (input valid, state_code, link_status, reload_address, connect_attempt,
                         close_request, send_slot, backoff_flag, error_count,
                   output ready);
endinterface

interface lcrs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lcrs_pkg::INDEX_BITS-1:0] index;
   logic [lcrs_pkg::DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/lcrs_step.sv -----
// Next-state and result logic of the supervisor for one tick.
module lcrs_step (
   input  lcrs_pkg::sup_type  cur,
   input  lcrs_pkg::cfg_type  cfg,
   input  lcrs_pkg::tick_type tick,
   output lcrs_pkg::sup_type  nxt,
   output lcrs_pkg::rsp_type  result
);
   import lcrs_pkg::*;

   state_type             state_n;
   logic                  moved;
   logic [TIMER_BITS-1:0] timer_n;
   logic [COUNT_BITS-1:0] tally_n;
   logic [1:0]            link_n;
   logic                  silence_n;
   logic                  reload;
   logic                  attempt;
   logic                  close_req;
   logic                  slot;
   logic                  timer_done;

   assign timer_done = (cur.timer == '0);

   // State transitions and entry actions.
   always_comb begin
      state_n   = cur.state;
      moved     = 1'b0;
      timer_n   = cur.timer;
      tally_n   = cur.tally;
      link_n    = tick.link_dropped ? LINK_CLOSED : cur.link;
      silence_n = cur.silence;
      reload    = 1'b0;
      attempt   = 1'b0;
      close_req = 1'b0;
      slot      = 1'b0;

      unique case (cur.state)
         ST_INVALID: begin
            if (cur.entry_pending) begin
               link_n  = LINK_CLOSED;
               timer_n = TIMER_BITS'(cfg.invalid_wait);
            end else if (timer_done && tick.modem_ready && cfg.enable) begin
               state_n = ST_CREATE;
               moved   = 1'b1;
            end
         end
         ST_CREATE: begin
            if (cur.entry_pending) begin
               reload  = 1'b1;
               timer_n = TIMER_BITS'(cfg.create_wait);
            end else if (timer_done) begin
               state_n = ST_CONNECT;
               moved   = 1'b1;
            end
         end
         ST_CONNECT: begin
            if (cur.entry_pending) begin
               link_n  = LINK_CONNECTING;
               attempt = 1'b1;
               if (tick.connect_failed) begin
                  tally_n = sat_inc(cur.tally);
                  state_n = ST_CLOSE;
                  moved   = 1'b1;
               end else begin
                  timer_n = TIMER_BITS'(cfg.connect_wait);
               end
            end else if (timer_done) begin
               state_n = ST_READY;
               moved   = 1'b1;
            end
         end
         ST_READY: begin
            if (cur.entry_pending) begin
               tally_n = '0;
               link_n  = LINK_READY;
            end else if (!tick.modem_ready) begin
               link_n  = LINK_CLOSED;
               state_n = ST_CLOSE;
               moved   = 1'b1;
            end else if (link_n == LINK_CLOSED) begin
               state_n = ST_CLOSE;
               moved   = 1'b1;
            end else begin
               // Steady ready tick: a send happens and may fail.
               slot = 1'b1;
               if (tick.send_failed) begin
                  tally_n = sat_inc(cur.tally);
               end
               if (tally_n > cfg.error_limit) begin
                  state_n = ST_CLOSE;
                  moved   = 1'b1;
               end
            end
         end
         ST_CLOSE: begin
            if (cur.entry_pending) begin
               link_n    = LINK_CLOSED;
               close_req = 1'b1;
               timer_n   = TIMER_BITS'(cfg.close_wait);
            end else if (timer_done) begin
               state_n = (cur.tally > cfg.error_limit) ? ST_SILENCE : ST_INVALID;
               moved   = 1'b1;
            end
         end
         ST_SILENCE: begin
            if (cur.entry_pending) begin
               link_n    = LINK_CLOSED;
               silence_n = 1'b1;
               timer_n   = TIMER_BITS'(cfg.silence_wait);
            end else if (timer_done) begin
               tally_n   = '0;
               silence_n = 1'b0;
               state_n   = ST_INVALID;
               moved     = 1'b1;
            end
         end
         default: begin
            state_n = ST_CLOSE;
            moved   = 1'b1;
         end
      endcase
   end

   // Timer counts down at the end of every tick and holds at zero.
   always_comb begin
      nxt.state         = state_n;
      nxt.entry_pending = moved;
      nxt.timer         = (timer_n != '0) ? timer_n - 1'b1 : timer_n;
      nxt.tally         = tally_n;
      nxt.link          = link_n;
      nxt.silence       = silence_n;
   end

   // Result of this tick.
   always_comb begin
      result.state_code      = code_of(state_n);
      result.link_status     = link_n;
      result.reload_address  = reload;
      result.connect_attempt = attempt;
      result.close_request   = close_req;
      result.send_slot       = slot;
      result.backoff_flag    = silence_n;
      result.error_count     = tally_n;
   end

endmodule

// ----- src/link_connect_retry_supervisor_core.sv -----
// Top level of the link connect/retry supervisor.
//
// Each request is one 10 ms tick and produces exactly one result. A request
// is taken into an input register, and the supervisor step logic then
// updates the state and writes the result register once that register is
// free, so a new request can be accepted in every cycle while the result
// channel does not stall. The sustained rate is one request per cycle; it
// falls only while the result channel stalls. Configuration writes are always
// accepted and take effect on the next request; write them only while no
// request is in flight.
module link_connect_retry_supervisor_core (
   input logic         clock,
   input logic         reset,
   lcrs_req_if.sink    req_if,
   lcrs_rsp_if.source  rsp_if,
   lcrs_csr_if.sink    csr_if
);
   import lcrs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   sup_type  sup_ff, sup_in;
   logic     tick_valid_ff;
   tick_type tick_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   rsp_type  step_rsp;
   logic     rsp_free;
   logic     advance;
   tick_type req_tick;

   // Pipeline flow: the step fires when the result register can take it.
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign advance      = tick_valid_ff && rsp_free;
   assign req_if.ready = !tick_valid_ff || advance;

   assign req_tick.modem_ready    = req_if.modem_ready;
   assign req_tick.connect_failed = req_if.connect_failed;
   assign req_tick.link_dropped   = req_if.link_dropped;
   assign req_tick.send_failed    = req_if.send_failed;

   // Configuration register writes.
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_ENABLE:       cfg_in.enable       = csr_if.data[0];
            CSR_INVALID_WAIT: cfg_in.invalid_wait = WAIT_BITS'(csr_if.data);
            CSR_CREATE_WAIT:  cfg_in.create_wait  = WAIT_BITS'(csr_if.data);
            CSR_CONNECT_WAIT: cfg_in.connect_wait = WAIT_BITS'(csr_if.data);
            CSR_CLOSE_WAIT:   cfg_in.close_wait   = WAIT_BITS'(csr_if.data);
            CSR_SILENCE_WAIT: cfg_in.silence_wait = WAIT_BITS'(csr_if.data);
            CSR_ERROR_LIMIT:  cfg_in.error_limit  = csr_if.data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         tick_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         tick_ff <= req_tick;
      end
   end

   // Supervisor step.
   lcrs_step u_step (
      .cur    (sup_ff),
      .cfg    (cfg_ff),
      .tick   (tick_ff),
      .nxt    (sup_in),
      .result (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sup_ff <= SUP_RESET;
      end else if (advance) begin
         sup_ff <= sup_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.state_code      = rsp_ff.state_code;
   assign rsp_if.link_status     = rsp_ff.link_status;
   assign rsp_if.reload_address  = rsp_ff.reload_address;
   assign rsp_if.connect_attempt = rsp_ff.connect_attempt;
   assign rsp_if.close_request   = rsp_ff.close_request;
   assign rsp_if.send_slot       = rsp_ff.send_slot;
   assign rsp_if.backoff_flag    = rsp_ff.backoff_flag;
   assign rsp_if.error_count     = rsp_ff.error_count;

endmodule

// ----- src/lcrs_checker.sv -----
// Port-level checks of the supervisor and their binding to the top level.
`include "link_connect_retry_supervisor_core_defines.svh"

module lcrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] state_code,
   input logic [1:0] link_status,
   input logic       reload_address,
   input logic       connect_attempt,
   input logic       close_request,
   input logic       send_slot,
   input logic       backoff_flag
);
   import lcrs_pkg::*;

   logic [3:0] pulses;
   logic       close_shown;

   assign pulses      = {reload_address, connect_attempt, close_request, send_slot};
   assign close_shown = (state_code == CODE_CLOSE) && (link_status == LINK_CLOSED);

   // A stalled result stays offered.
   `LCRS_CHECK_NEXT(rsp_hold_chk, rsp_valid && !rsp_ready, rsp_valid)

   // At most one action pulse per tick.
   `LCRS_CHECK(pulse_excl_chk, rsp_valid, $onehot0(pulses))

   // The backoff flag is only ever shown while the supervisor is in silence.
   // The tick that moves into silence still shows it low.
   `LCRS_CHECK(backoff_chk, rsp_valid && backoff_flag, state_code == CODE_SILENCE)

   // A close request comes from close entry, with the link marked closed.
   `LCRS_CHECK(close_chk, rsp_valid && close_request, close_shown)

endmodule

bind link_connect_retry_supervisor_core lcrs_checker u_lcrs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .state_code      (rsp_if.state_code),
   .link_status     (rsp_if.link_status),
   .reload_address  (rsp_if.reload_address),
   .connect_attempt (rsp_if.connect_attempt),
   .close_request   (rsp_if.close_request),
   .send_slot       (rsp_if.send_slot),
   .backoff_flag    (rsp_if.backoff_flag)
);
